// ----- hdl/mll_pkg.sv -----
// Shared types, constants and helper functions for the markup lexer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mll_pkg;
  localparam int unsigned POSITION_WIDTH = 16;
  localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};

  localparam logic [2:0] K_IDENT = 3'd0;
  localparam logic [2:0] K_STR = 3'd1;
  localparam logic [2:0] K_INT = 3'd2;
  localparam logic [2:0] K_OP = 3'd3;
  localparam logic [2:0] K_BAD = 3'd4;
  localparam logic [2:0] K_UNTERM = 3'd5;
  localparam logic [2:0] K_DONE = 3'd6;

  localparam logic [4:0] OP_NONE = 5'd31;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  chr;
    logic [31:0] ival;
    logic [4:0]  op;
    logic [15:0] line;
    logic [15:0] col;
    logic        last;
  } tok_t;

  typedef struct packed {
    logic [1:0] n;
    tok_t       t0;
    tok_t       t1;
    tok_t       t2;
  } grp_t;

  function automatic logic [4:0] single_code(input logic [7:0] c);
    logic [4:0] r;
    r = OP_NONE;
    case (c)
      8'h28: r = 5'd4;
      8'h29: r = 5'd5;
      8'h7b: r = 5'd6;
      8'h7d: r = 5'd7;
      8'h5b: r = 5'd8;
      8'h5d: r = 5'd9;
      8'h3c: r = 5'd10;
      8'h3e: r = 5'd11;
      8'h40: r = 5'd12;
      8'h2a: r = 5'd13;
      8'h2b: r = 5'd14;
      8'h21: r = 5'd15;
      8'h2c: r = 5'd16;
      8'h3f: r = 5'd17;
      8'h3a: r = 5'd18;
      8'h2d: r = 5'd19;
      8'h3d: r = 5'd20;
      8'h3b: r = 5'd21;
      8'h2f: r = 5'd22;
      8'h24: r = 5'd23;
      8'h7e: r = 5'd24;
      8'h7c: r = 5'd25;
      default: r = OP_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] pair_code(input logic [7:0] a, input logic [7:0] b);
    logic [4:0] r;
    r = OP_NONE;
    if (a == 8'h3d && b == 8'h3e) r = 5'd0;
    else if (a == 8'h2d && b == 8'h3e) r = 5'd1;
    else if (a == 8'h3c && b == 8'h2d) r = 5'd2;
    else if (a == 8'h24 && b == 8'h24) r = 5'd3;
    return r;
  endfunction

  function automatic logic [4:0] digit_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd31;
    if (c >= 8'h30 && c <= 8'h39) r = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h7a && c <= 8'h7a - 8'd10) r = 5'(c - 8'h61 + 8'd10);
    else if (c >= 8'h41 && c <= 8'h5a && c <= 8'h5a - 8'd10) r = 5'(c - 8'h41 + 8'd10);
    else if ((c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a)) r = 5'd30;
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- hdl/mll_front.sv -----
// Front end: accepts source bytes, tracks position and runs the lexer state machine.
// Produces up to two result words per byte as one group. Depends on mll_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mll_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   in_byte,
  input  wire logic         in_end_of_input,
  output logic              grp_valid,
  input  wire logic         grp_ready,
  output mll_pkg::grp_t     grp
);
  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_IDENT, M_NUM_ZERO, M_NUM, M_STR, M_ESC, M_OCT, M_HEX, M_OP
  } mode_t;

  localparam int unsigned PW = mll_pkg::POSITION_WIDTH;

  mode_t mode_r, mode_nxt;
  logic [7:0] held_r, held_nxt;
  logic hvalid_r, hvalid_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [1:0] base_r, base_nxt;
  logic [7:0] esc_r, esc_nxt;
  logic [1:0] ecnt_r, ecnt_nxt;
  logic [7:0] quote_r, quote_nxt;
  logic [PW-1:0] line_r, line_nxt, col_r, col_nxt, tline_r, tline_nxt, tcol_r, tcol_nxt;
  logic halted_r, halted_nxt;

  logic fire;
  mll_pkg::tok_t t [3];
  logic [1:0] n;

  assign in_ready = grp_ready;
  assign fire = in_valid && in_ready;
  assign grp_valid = fire;
  assign grp.n = n;
  assign grp.t0 = t[0];
  assign grp.t1 = t[1];
  assign grp.t2 = t[2];

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction
  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction
  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  always_comb begin
    logic [7:0] c;
    logic [4:0] d;
    logic [4:0] code;
    logic [4:0] rad;
    logic again;
    logic [7:0] ev;
    mode_nxt = mode_r; held_nxt = held_r; hvalid_nxt = hvalid_r; acc_nxt = acc_r;
    base_nxt = base_r; esc_nxt = esc_r; ecnt_nxt = ecnt_r; quote_nxt = quote_r;
    line_nxt = line_r; col_nxt = col_r; tline_nxt = tline_r; tcol_nxt = tcol_r;
    halted_nxt = halted_r;
    n = 2'd0;
    for (int i = 0; i < 3; i++) t[i] = '0;
    c = in_byte;
    d = '0; code = '0; again = 1'b0; ev = '0;
    case (base_r)
      2'd1: rad = 5'd16;
      2'd2: rad = 5'd8;
      2'd3: rad = 5'd2;
      default: rad = 5'd10;
    endcase
    if (in_end_of_input) begin
      if (!halted_r) begin
        case (mode_r)
          M_IDENT: begin
            t[0] = '{mll_pkg::K_IDENT, held_r, 32'd0, 5'd0, 16'(tline_r), 16'(tcol_r), 1'b1};
            n = 2'd1;
          end
          M_NUM_ZERO, M_NUM: begin
            t[0] = '{mll_pkg::K_INT, 8'd0, acc_r, 5'd0, 16'(tline_r), 16'(tcol_r), 1'b1};
            n = 2'd1;
          end
          M_STR, M_ESC, M_OCT, M_HEX: begin
            t[0] = '{mll_pkg::K_UNTERM, quote_r, 32'd0, 5'd0, 16'(tline_r), 16'(tcol_r), 1'b1};
            n = 2'd1;
          end
          M_OP: begin
            t[0] = '{mll_pkg::K_OP, 8'd0, 32'd0, mll_pkg::single_code(held_r), 16'(tline_r),
                     16'(tcol_r), 1'b1};
            n = 2'd1;
          end
          default: n = 2'd0;
        endcase
      end
      t[n] = '{mll_pkg::K_DONE, 8'd0, 32'd0, 5'd0, 16'(line_r), 16'(col_r), 1'b1};
      n = n + 2'd1;
      mode_nxt = M_IDLE; held_nxt = '0; hvalid_nxt = 1'b0; acc_nxt = '0; base_nxt = '0;
      esc_nxt = '0; ecnt_nxt = '0; quote_nxt = '0; line_nxt = PW'(1); col_nxt = PW'(1);
      tline_nxt = PW'(1); tcol_nxt = PW'(1); halted_nxt = 1'b0;
    end else if (!halted_r) begin
      // first pass: current mode; may hand the byte back to idle handling
      case (mode_r)
        M_COMMENT: if (c == 8'h0a) mode_nxt = M_IDLE;
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            t[0] = '{mll_pkg::K_IDENT, held_r, 32'd0, 5'd0, 16'(tline_r), 16'(tcol_r), 1'b0};
            n = 2'd1; held_nxt = c;
          end else begin
            t[0] = '{mll_pkg::K_IDENT, held_r, 32'd0, 5'd0, 16'(tline_r), 16'(tcol_r), 1'b1};
            n = 2'd1; hvalid_nxt = 1'b0; again = 1'b1;
          end
        end
        M_NUM_ZERO, M_NUM: begin
          d = mll_pkg::digit_value(c);
          if (mode_r == M_NUM_ZERO && (c == 8'h78 || c == 8'h58)) begin
            base_nxt = 2'd1; mode_nxt = M_NUM;
          end else if (mode_r == M_NUM_ZERO && (c == 8'h6f || c == 8'h4f)) begin
            base_nxt = 2'd2; mode_nxt = M_NUM;
          end else if (mode_r == M_NUM_ZERO && (c == 8'h62 || c == 8'h42)) begin
            base_nxt = 2'd3; mode_nxt = M_NUM;
          end else if (d < rad) begin
            mode_nxt = M_NUM;
            case (base_r)
              2'd1: acc_nxt = {acc_r[27:0], 4'd0} + 32'(d);
              2'd2: acc_nxt = {acc_r[28:0], 3'd0} + 32'(d);
              2'd3: acc_nxt = {acc_r[30:0], 1'b0} + 32'(d);
              default: acc_nxt = {acc_r[28:0], 3'd0} + {acc_r[30:0], 1'b0} + 32'(d);
            endcase
          end else begin
            t[0] = '{mll_pkg::K_INT, 8'd0, acc_r, 5'd0, 16'(tline_r), 16'(tcol_r), 1'b1};
            n = 2'd1; again = 1'b1;
          end
        end
        M_STR: begin
          if (c == quote_r) begin
            t[0] = '{mll_pkg::K_STR, hvalid_r ? held_r : 8'd0, 32'd0, 5'd0, 16'(tline_r),
                     16'(tcol_r), 1'b1};
            n = 2'd1; hvalid_nxt = 1'b0; mode_nxt = M_IDLE;
          end else if (c == 8'h5c) begin
            mode_nxt = M_ESC;
          end else begin
            if (hvalid_r) begin
              t[0] = '{mll_pkg::K_STR, held_r, 32'd0, 5'd0, 16'(tline_r), 16'(tcol_r), 1'b0};
              n = 2'd1;
            end
            held_nxt = c; hvalid_nxt = 1'b1;
          end
        end
        M_ESC: begin
          if (c >= 8'h30 && c <= 8'h37) begin
            esc_nxt = {5'd0, c[2:0]}; ecnt_nxt = 2'd1; mode_nxt = M_OCT;
          end else if (c == 8'h78) begin
            esc_nxt = '0; ecnt_nxt = '0; mode_nxt = M_HEX;
          end else begin
            case (c)
              8'h61: ev = 8'd7;
              8'h62: ev = 8'd8;
              8'h74: ev = 8'd9;
              8'h6e: ev = 8'd10;
              8'h76: ev = 8'd11;
              8'h66: ev = 8'd12;
              8'h72: ev = 8'd13;
              default: ev = c;
            endcase
            if (hvalid_r) begin
              t[0] = '{mll_pkg::K_STR, held_r, 32'd0, 5'd0, 16'(tline_r), 16'(tcol_r), 1'b0};
              n = 2'd1;
            end
            held_nxt = ev; hvalid_nxt = 1'b1; mode_nxt = M_STR;
          end
        end
        M_OCT, M_HEX: begin
          d = mll_pkg::digit_value(c);
          if (mode_r == M_OCT && c >= 8'h30 && c <= 8'h37 && ecnt_r < 2'd3) begin
            ev = {esc_r[4:0], c[2:0]};
          end else if (mode_r == M_HEX && d < 5'd16 && ecnt_r < 2'd2) begin
            ev = {esc_r[3:0], d[3:0]};
          end else begin
            again = 1'b1;
          end
          if (!again) begin
            esc_nxt = ev; ecnt_nxt = ecnt_r + 2'd1;
            if ((mode_r == M_OCT && ecnt_r == 2'd2) || (mode_r == M_HEX && ecnt_r == 2'd1)) begin
              if (hvalid_r) begin
                t[0] = '{mll_pkg::K_STR, held_r, 32'd0, 5'd0, 16'(tline_r), 16'(tcol_r), 1'b0};
                n = 2'd1;
              end
              held_nxt = ev; hvalid_nxt = 1'b1; mode_nxt = M_STR;
            end
          end else begin
            if (hvalid_r) begin
              t[0] = '{mll_pkg::K_STR, held_r, 32'd0, 5'd0, 16'(tline_r), 16'(tcol_r), 1'b0};
              n = 2'd1;
            end
            held_nxt = esc_r; hvalid_nxt = 1'b1; mode_nxt = M_STR; again = 1'b0;
            // re-lex terminating byte in string mode
            if (c == quote_r) begin
              t[n] = '{mll_pkg::K_STR, esc_r, 32'd0, 5'd0, 16'(tline_r), 16'(tcol_r), 1'b1};
              n = n + 2'd1; hvalid_nxt = 1'b0; mode_nxt = M_IDLE;
            end else if (c == 8'h5c) begin
              mode_nxt = M_ESC;
            end else begin
              t[n] = '{mll_pkg::K_STR, esc_r, 32'd0, 5'd0, 16'(tline_r), 16'(tcol_r), 1'b0};
              n = n + 2'd1; held_nxt = c;
            end
          end
        end
        M_OP: begin
          code = mll_pkg::pair_code(held_r, c);
          mode_nxt = M_IDLE;
          if (code != mll_pkg::OP_NONE) begin
            t[0] = '{mll_pkg::K_OP, 8'd0, 32'd0, code, 16'(tline_r), 16'(tcol_r), 1'b1};
          end else begin
            t[0] = '{mll_pkg::K_OP, 8'd0, 32'd0, mll_pkg::single_code(held_r), 16'(tline_r),
                     16'(tcol_r), 1'b1};
            again = 1'b1;
          end
          n = 2'd1;
        end
        default: again = 1'b1;
      endcase
      if (again) begin
        mode_nxt = M_IDLE; tline_nxt = line_r; tcol_nxt = col_r;
        code = mll_pkg::single_code(c);
        if (is_space(c)) begin
          mode_nxt = M_IDLE;
        end else if (c == 8'h23) begin
          mode_nxt = M_COMMENT;
        end else if (is_alpha(c)) begin
          held_nxt = c; mode_nxt = M_IDENT;
        end else if (is_digit(c)) begin
          acc_nxt = {28'd0, c[3:0]}; base_nxt = 2'd0;
          mode_nxt = (c == 8'h30) ? M_NUM_ZERO : M_NUM;
        end else if (c == 8'h27 || c == 8'h22) begin
          quote_nxt = c; hvalid_nxt = 1'b0; mode_nxt = M_STR;
        end else if (c == 8'h3d || c == 8'h2d || c == 8'h3c || c == 8'h24) begin
          held_nxt = c; mode_nxt = M_OP;
        end else if (code != mll_pkg::OP_NONE) begin
          t[n] = '{mll_pkg::K_OP, 8'd0, 32'd0, code, 16'(line_r), 16'(col_r), 1'b1};
          n = n + 2'd1;
        end else begin
          t[n] = '{mll_pkg::K_BAD, c, 32'd0, 5'd0, 16'(line_r), 16'(col_r), 1'b1};
          n = n + 2'd1; halted_nxt = 1'b1;
        end
      end
      if (c == 8'h0a) begin
        if (line_r != mll_pkg::POS_MAX) line_nxt = line_r + PW'(1);
        col_nxt = PW'(1);
      end else if (col_r != mll_pkg::POS_MAX) begin
        col_nxt = col_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; held_r <= '0; hvalid_r <= 1'b0; acc_r <= '0; base_r <= '0;
      esc_r <= '0; ecnt_r <= '0; quote_r <= '0; line_r <= PW'(1); col_r <= PW'(1);
      tline_r <= PW'(1); tcol_r <= PW'(1); halted_r <= 1'b0;
    end else if (fire) begin
      mode_r <= mode_nxt; held_r <= held_nxt; hvalid_r <= hvalid_nxt; acc_r <= acc_nxt;
      base_r <= base_nxt; esc_r <= esc_nxt; ecnt_r <= ecnt_nxt; quote_r <= quote_nxt;
      line_r <= line_nxt; col_r <= col_nxt; tline_r <= tline_nxt; tcol_r <= tcol_nxt;
      halted_r <= halted_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/mll_back.sv -----
// Back end: two-entry queue of result groups, drained one word per cycle while out_ready is high.
// Depends on mll_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mll_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         grp_valid,
  output logic              grp_ready,
  input  wire mll_pkg::grp_t grp,
  output logic              out_valid,
  input  wire logic         out_ready,
  output mll_pkg::tok_t     tok
);
  mll_pkg::grp_t q_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic [1:0] idx_r;
  logic push, pop, head_ok;
  mll_pkg::grp_t h;

  assign h = q_r[rp_r];
  assign head_ok = (cnt_r != 2'd0) && (h.n != 2'd0);
  assign grp_ready = cnt_r != 2'd2;
  assign push = grp_valid && grp_ready && grp.n != 2'd0;
  assign out_valid = head_ok;
  assign pop = (cnt_r != 2'd0) && ((out_valid && out_ready && idx_r == h.n - 2'd1));

  always_comb begin
    case (idx_r)
      2'd0: tok = h.t0;
      2'd1: tok = h.t1;
      default: tok = h.t2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= grp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0; idx_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) begin
        rp_r <= ~rp_r; idx_r <= '0;
      end else if (out_valid && out_ready) begin
        idx_r <= idx_r + 2'd1;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ----- hdl/markup_language_lexer.sv -----
// Streaming lexer top level: front state machine, group queue, word output.
// Depends on mll_pkg, mll_front, mll_back.
//
// Input channel: one source byte per word (in_byte), or an end marker
// (in_end_of_input) that flushes the pending token and emits a done word.
// Output channel: one result word per handshake; a byte causes 0 to 2 words.
// Throughput: one byte per cycle while each byte yields at most one word
// and out_ready is high; a byte's words leave one per handshake. The rate
// is set by the single output port draining the group queue.
// Latency: a word is visible the cycle after its byte if the queue was empty.
// A two-group queue decouples the sides; in_ready drops only when it is full,
// so a stalled receiver backs up into the input after two groups.
// Reset (rst_n low, synchronous) returns to line 1, column 1, between tokens,
// and empties the queue.
`timescale 1ns / 1ps
`default_nettype none
module markup_language_lexer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_end_of_input,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_token_kind,
  output logic [7:0]       out_char_value,
  output logic [31:0]      out_int_value,
  output logic [4:0]       out_op_code,
  output logic [15:0]      out_start_line,
  output logic [15:0]      out_start_column,
  output logic             out_token_last
);
  logic gv, gr;
  mll_pkg::grp_t g;
  mll_pkg::tok_t tk;

  mll_front u_front (.clk, .rst_n, .in_valid, .in_ready, .in_byte, .in_end_of_input,
                     .grp_valid(gv), .grp_ready(gr), .grp(g));
  mll_back u_back (.clk, .rst_n, .grp_valid(gv), .grp_ready(gr), .grp(g),
                   .out_valid, .out_ready, .tok(tk));

  assign out_token_kind = tk.kind;
  assign out_char_value = tk.chr;
  assign out_int_value = tk.ival;
  assign out_op_code = tk.op;
  assign out_start_line = tk.line;
  assign out_start_column = tk.col;
  assign out_token_last = tk.last;

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind == mll_pkg::K_BAD || out_token_kind == mll_pkg::K_DONE)
    |-> out_token_last) else $error("error word without last");
  a_line_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_start_line != 16'd0) else $error("zero line");
  a_done_eoi: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_input |=> out_valid) else $error("no done word");
endmodule
`default_nettype wire
